// ===== src/mrs_pkg.sv =====
package mrs_pkg;

    // Event kind codes on the result channel
    localparam logic [2:0] KIND_REALTIME = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd2;
    localparam logic [2:0] KIND_CTRL     = 3'd3;
    localparam logic [2:0] KIND_PITCH    = 3'd4;

    // MIDI status byte values and boundaries
    localparam logic [7:0] ST_NONE     = 8'h00;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_CTRL     = 8'hB0;
    localparam logic [7:0] ST_PROGRAM  = 8'hC0;
    localparam logic [7:0] ST_PITCH    = 8'hE0;
    localparam logic [7:0] ST_SYSTEM   = 8'hF0;
    localparam logic [7:0] ST_SONG_POS = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL = 8'hF3;
    localparam logic [7:0] ST_TUNE     = 8'hF6;
    localparam logic [7:0] ST_REALTIME = 8'hF8;
    localparam logic [7:0] ST_HI_MASK  = 8'hF0;

    // Parser state carried from byte to byte
    typedef struct packed {
        logic [7:0] running_status;
        logic       second_pending;
        logic [7:0] held_data;
    } t_state;

    // One decoded event
    typedef struct packed {
        logic       valid;
        logic [2:0] event_kind;
        logic [7:0] first_data;
        logic [6:0] second_data;
        logic [7:0] realtime_byte;
    } t_event;

endpackage

// ===== src/mrs_decode.sv =====
module mrs_decode
    import mrs_pkg::*;
(
    input  logic [7:0] i_byte,
    input  t_state     i_state,
    output t_state     o_state,
    output t_event     o_event
);

    // Single-pass decode of one byte against the current state
    always_comb begin
        o_state = i_state;
        o_event = '0;
        if (i_byte[7]) begin
            // Status byte: realtime passes through, others become running status
            if (i_byte >= ST_REALTIME) begin
                o_event.valid         = 1'b1;
                o_event.event_kind    = KIND_REALTIME;
                o_event.realtime_byte = i_byte;
            end else begin
                o_state.running_status = i_byte;
                o_state.second_pending = 1'b0;
                if (i_byte == ST_TUNE) begin
                    o_state.held_data = i_byte;
                end
            end
        end else if (i_state.second_pending) begin
            // Second data byte completes a two-byte message
            o_state.second_pending = 1'b0;
            o_state.running_status = i_state.running_status & ST_HI_MASK;
            o_event.first_data     = i_state.held_data;
            o_event.second_data    = i_byte[6:0];
            priority if (o_state.running_status == ST_NOTE_ON) begin
                o_event.valid      = 1'b1;
                o_event.event_kind = (i_byte == 8'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            end else if (o_state.running_status == ST_NOTE_OFF) begin
                o_event.valid      = 1'b1;
                o_event.event_kind = KIND_NOTE_OFF;
            end else if (o_state.running_status == ST_PITCH) begin
                o_event.valid      = 1'b1;
                o_event.event_kind = KIND_PITCH;
            end else if (o_state.running_status == ST_CTRL) begin
                o_event.valid      = 1'b1;
                o_event.event_kind = KIND_CTRL;
            end else begin
                o_event.valid = 1'b0;
            end
        end else if (i_state.running_status != ST_NONE) begin
            // First data byte under the running status
            priority if (i_state.running_status < ST_PROGRAM) begin
                o_state.second_pending = 1'b1;
                o_state.held_data      = i_byte;
            end else if (i_state.running_status < ST_PITCH) begin
                o_state.held_data = i_byte;
            end else if (i_state.running_status < ST_SYSTEM) begin
                o_state.second_pending = 1'b1;
                o_state.held_data      = i_byte;
            end else if (i_state.running_status == ST_SONG_POS) begin
                o_state.running_status = ST_NONE;
                o_state.second_pending = 1'b1;
                o_state.held_data      = i_byte;
            end else if (i_state.running_status == ST_SONG_SEL) begin
                o_state.running_status = ST_NONE;
                o_state.held_data      = i_byte;
            end else begin
                o_state.running_status = ST_NONE;
            end
        end
    end

endmodule

// ===== src/midi_running_status_parser.sv =====
// A byte is taken into the input register, decoded there, and its event loads the output register once free.
// One byte per cycle while no event waits on a stalled output; parser state updates as each byte advances.
// A byte without an event never waits; one with an event waits only for a free
// output register. Input register plus output register decouple the two sides.
// Reset (synchronous, active low) empties both stages and zeroes the parser state.
module midi_running_status_parser
    import mrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_ev_valid,
    input  logic       i_ev_ready,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_first_data,
    output logic [6:0] o_second_data,
    output logic [7:0] o_realtime_byte
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_event     n_event;
    logic       r_out_valid;
    t_event     r_out;
    logic       out_free;
    logic       advance;

    mrs_decode u_decode (
        .i_byte  (r_in_byte),
        .i_state (r_state),
        .o_state (n_state),
        .o_event (n_event)
    );

    // Byte leaves the input register when its event, if any, has a slot
    assign out_free   = !r_out_valid || i_ev_ready;
    assign advance    = r_in_valid && (!n_event.valid || out_free);
    assign o_rx_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_event.valid;
        end
        if (out_free && advance && n_event.valid) begin
            r_out <= n_event;
        end
    end

    assign o_ev_valid      = r_out_valid;
    assign o_event_kind    = r_out.event_kind;
    assign o_first_data    = r_out.first_data;
    assign o_second_data   = r_out.second_data;
    assign o_realtime_byte = r_out.realtime_byte;

endmodule

// ===== src/mrs_checker.sv =====
module mrs_checker
    import mrs_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ev_valid,
    input logic       i_ev_ready,
    input logic [2:0] o_event_kind,
    input logic [7:0] o_first_data,
    input logic [6:0] o_second_data,
    input logic [7:0] o_realtime_byte
);

    // Realtime events carry a realtime byte and no data
    a_realtime_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev_valid && o_event_kind == KIND_REALTIME) |->
            (o_realtime_byte >= ST_REALTIME && o_first_data == 8'd0
             && o_second_data == 7'd0))
        else $error("realtime event fields wrong");

    // Channel events carry no realtime byte and a known kind
    a_channel_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev_valid && o_event_kind != KIND_REALTIME) |->
            (o_realtime_byte == 8'd0 &&
             (o_event_kind == KIND_NOTE_ON || o_event_kind == KIND_NOTE_OFF
              || o_event_kind == KIND_CTRL || o_event_kind == KIND_PITCH)))
        else $error("channel event fields wrong");

    // Note on never reports zero velocity
    a_note_on_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev_valid && o_event_kind == KIND_NOTE_ON) |-> o_second_data != 7'd0)
        else $error("note on with zero velocity");

    // No event right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ev_valid)
        else $error("event valid after reset");

    // A stalled event holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev_valid && !i_ev_ready) |=>
            (o_ev_valid && $stable(o_event_kind) && $stable(o_first_data)
             && $stable(o_second_data) && $stable(o_realtime_byte)))
        else $error("stalled event changed");

endmodule

bind midi_running_status_parser mrs_checker u_mrs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ev_valid      (o_ev_valid),
    .i_ev_ready      (i_ev_ready),
    .o_event_kind    (o_event_kind),
    .o_first_data    (o_first_data),
    .o_second_data   (o_second_data),
    .o_realtime_byte (o_realtime_byte)
);
